@@ src/sibm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes of the sparse image block mapper.
package sibm_pkg;

    // input command codes (carried in tuser)
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // result kinds (carried in tuser)
    localparam logic [1:0] KIND_ENTRY   = 2'd0;
    localparam logic [1:0] KIND_FLUSH   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_BLOCK_BITS  = 2'd0;
    localparam logic [1:0] REG_SECOND_BITS = 2'd1;
    localparam logic [1:0] REG_FIRST_BITS  = 2'd2;

    localparam int TI_W   = 18;
    localparam int SI_W   = 13;
    localparam int VAL_W  = 64;
    localparam int SIZE_W = 48;

    // result queue geometry
    localparam int MAX_RES  = 3;
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TI_W-1:0]   table_index;
        logic [SI_W-1:0]   entry_index;
        logic [VAL_W-1:0]  value;
        logic              copies_block;
        logic [SIZE_W-1:0] byte_total;
        logic              last;
    } res_t;

    // results raised by one request, in order from slot 0
    typedef struct packed {
        res_t [MAX_RES-1:0] res;
        logic [1:0]         cnt;
    } batch_t;

endpackage

@@ src/sparse_image_block_mapper_unit.sv @@
`timescale 1ns / 1ps
// Sparse disk image block mapper, top level.
//
// Input stream: one request per image word (tuser = 0) or an end-of-image
// marker (tuser = 1). Words are grouped into blocks; each finished block is
// classed as all zero, uniform or data and yields map entries, table
// flushes, an end summary or an overflow error on the result stream.
// Each request raises zero to three results; the last of them carries tlast.
// Results of a request are written into the result queue as it is
// accepted. A request is taken every cycle while the three-deep-plus-one
// result queue has room for a full batch, so the rate is one request per
// cycle when results are sparse and is set by the result port (one result a
// cycle) otherwise. s_axis_tready drops while two or more results wait.
// When the receiver stalls, results stay queued and in order; nothing is lost.
// Reset (aresetn low, synchronous) restores the register defaults (12, 9, 9),
// empties the queue and restarts the stream with the offset at one block.
// A configuration write also restarts the stream; write only while idle.
module sparse_image_block_mapper_unit #(
    parameter int OFFSET_BITS    = 48,
    parameter int MAX_BLOCK_BITS = 16,
    parameter int MAX_FIRST_BITS = 17
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [4:0]   cfg_data,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // data_word[31:0], valid_bytes[34:32], zero pad
    input  logic [0:0]   s_axis_tuser,   // command[0]
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // table_index[17:0], entry_index[30:18], value[94:31], copies_block[95],
    // byte_total[143:96]
    output logic [143:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // kind[1:0]
    output logic         m_axis_tlast
);
    import sibm_pkg::*;

    batch_t batch;
    res_t   head;
    logic   space_ok;
    logic   accept;

    assign s_axis_tready = space_ok;
    assign accept        = s_axis_tvalid && space_ok;

    sibm_core #(
        .OFFSET_BITS    (OFFSET_BITS),
        .MAX_BLOCK_BITS (MAX_BLOCK_BITS),
        .MAX_FIRST_BITS (MAX_FIRST_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_valid  (accept),
        .item_cmd    (s_axis_tuser[0]),
        .item_word   (s_axis_tdata[31:0]),
        .item_vbytes (s_axis_tdata[34:32]),
        .batch       (batch)
    );

    sibm_res_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .batch    (batch),
        .space_ok (space_ok),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .head     (head)
    );

    assign m_axis_tdata = {head.byte_total, head.copies_block, head.value,
                           head.entry_index, head.table_index};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

@@ src/sibm_core.sv @@
`timescale 1ns / 1ps
// Block classification, table bookkeeping and configuration registers.
module sibm_core #(
    parameter int OFFSET_BITS    = 48,
    parameter int MAX_BLOCK_BITS = 16,
    parameter int MAX_FIRST_BITS = 17
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [4:0]      cfg_data,
    input  logic            item_valid,
    input  logic            item_cmd,
    input  logic [31:0]     item_word,
    input  logic [2:0]      item_vbytes,
    output sibm_pkg::batch_t batch
);
    import sibm_pkg::*;

    localparam int WIB_W = MAX_BLOCK_BITS - 2;
    localparam int FI_W  = MAX_FIRST_BITS + 1;
    localparam logic [4:0] MIN_BLOCK  = 5'd12;
    localparam logic [4:0] MAX_BLOCK  = 5'(MAX_BLOCK_BITS);
    localparam logic [3:0] MIN_SECOND = 4'd9;
    localparam logic [3:0] MAX_SECOND = 4'd13;
    localparam logic [4:0] MIN_FIRST  = 5'd9;
    localparam logic [4:0] MAX_FIRST  = 5'(MAX_FIRST_BITS);

    logic [4:0] block_bits_reg;
    logic [3:0] second_bits_reg;
    logic [4:0] first_bits_reg;

    logic [OFFSET_BITS-1:0] offset_reg;
    logic [SIZE_W-1:0]      bytes_reg;
    logic [WIB_W-1:0]       wib_reg;
    logic [SI_W-1:0]        si_reg;
    logic [FI_W-1:0]        fi_reg;
    logic                   tm_reg;
    logic                   zero_reg;
    logic                   uni_reg;
    logic [31:0]            fw_reg;
    logic                   ovf_reg;

    logic [4:0] eb, ef, bb_src, eb_rst;
    logic [3:0] es;
    logic [WIB_W-1:0] wpb_m1;
    logic [SI_W-1:0]  si_m1;
    logic [FI_W-1:0]  fi_cap;
    logic [OFFSET_BITS-1:0] blk_size, tbl_size, off_rst;
    logic [OFFSET_BITS-1:0] off_b, off_t, off_bt, off1, off_sel;
    logic [2:0]  v_eff;
    logic [31:0] w_m, fw_cur, blk_fw;
    logic start, fi_full, data_go, end_go, err, data_ok, cfg_hit, restart;
    logic z_d, u_d, fin, blk_z, blk_u, entry, copy, tm1, wrap, flush;

    // register clamps
    always_comb begin
        if (block_bits_reg < MIN_BLOCK) begin
            eb = MIN_BLOCK;
        end else if (block_bits_reg > MAX_BLOCK) begin
            eb = MAX_BLOCK;
        end else begin
            eb = block_bits_reg;
        end
        if (second_bits_reg < MIN_SECOND) begin
            es = MIN_SECOND;
        end else if (second_bits_reg > MAX_SECOND) begin
            es = MAX_SECOND;
        end else begin
            es = second_bits_reg;
        end
        if (first_bits_reg < MIN_FIRST) begin
            ef = MIN_FIRST;
        end else if (first_bits_reg > MAX_FIRST) begin
            ef = MAX_FIRST;
        end else begin
            ef = first_bits_reg;
        end
    end

    // block size after a restart follows a block_bits write in the same cycle
    assign cfg_hit = cfg_we && (cfg_index == REG_BLOCK_BITS || cfg_index == REG_SECOND_BITS
                                || cfg_index == REG_FIRST_BITS);
    assign bb_src  = (cfg_we && cfg_index == REG_BLOCK_BITS) ? cfg_data : block_bits_reg;

    always_comb begin
        if (!aresetn || bb_src < MIN_BLOCK) begin
            eb_rst = MIN_BLOCK;
        end else if (bb_src > MAX_BLOCK) begin
            eb_rst = MAX_BLOCK;
        end else begin
            eb_rst = bb_src;
        end
    end

    assign off_rst  = {{(OFFSET_BITS-1){1'b0}}, 1'b1} << eb_rst;
    assign blk_size = {{(OFFSET_BITS-1){1'b0}}, 1'b1} << eb;
    assign tbl_size = {{(OFFSET_BITS-1){1'b0}}, 1'b1} << ({1'b0, es} + 5'd3);
    assign wpb_m1   = ~({WIB_W{1'b1}} << (eb - 5'd2));
    assign si_m1    = ~({SI_W{1'b1}} << es);
    assign fi_cap   = {{(FI_W-1){1'b0}}, 1'b1} << ef;

    // byte count and low-byte masking
    always_comb begin
        v_eff = (item_vbytes > 3'd4) ? 3'd4 : item_vbytes;
        case (v_eff)
            3'd1:    w_m = item_word & 32'hFF00_0000;
            3'd2:    w_m = item_word & 32'hFFFF_0000;
            3'd3:    w_m = item_word & 32'hFFFF_FF00;
            default: w_m = item_word;
        endcase
    end

    assign start   = (wib_reg == '0);
    assign fi_full = (fi_reg >= fi_cap);
    assign data_go = item_valid && item_cmd == CMD_DATA && !ovf_reg && v_eff != 3'd0;
    assign end_go  = item_valid && item_cmd == CMD_END && !ovf_reg;
    assign err     = (item_valid && item_cmd == CMD_END && ovf_reg)
                   || (data_go && start && fi_full);
    assign data_ok = data_go && !(start && fi_full);

    assign fw_cur = start ? w_m : fw_reg;
    assign z_d    = (start || zero_reg) && (w_m == 32'd0);
    assign u_d    = (start || uni_reg) && (w_m == fw_cur);

    // a partial block at end of image is padded with zero words
    assign fin    = (data_ok && wib_reg == wpb_m1) || (end_go && !start);
    assign blk_z  = (item_cmd == CMD_DATA) ? z_d : zero_reg;
    assign blk_u  = (item_cmd == CMD_DATA) ? u_d : (uni_reg && fw_reg == 32'd0);
    assign blk_fw = (item_cmd == CMD_DATA) ? fw_cur : fw_reg;
    assign entry  = fin && !blk_z;
    assign copy   = entry && !blk_u;
    assign tm1    = tm_reg || entry;
    assign wrap   = fin && (si_reg == si_m1);
    assign flush  = tm1 && (wrap || end_go);

    assign off_b  = offset_reg + blk_size;
    assign off_t  = offset_reg + tbl_size;
    assign off_bt = offset_reg + (blk_size + tbl_size);
    assign off1   = copy ? off_b : offset_reg;

    always_comb begin
        case ({copy, flush})
            2'b11:   off_sel = off_bt;
            2'b10:   off_sel = off_b;
            2'b01:   off_sel = off_t;
            default: off_sel = offset_reg;
        endcase
    end

    always_comb begin
        logic [1:0] idx;
        res_t       r;
        batch = '0;
        idx   = 2'd0;
        r     = '0;
        if (err) begin
            r.kind        = KIND_ERROR;
            r.table_index = TI_W'(fi_reg);
            batch.res[0]  = r;
            idx           = 2'd1;
        end else begin
            if (entry) begin
                r              = '0;
                r.kind         = KIND_ENTRY;
                r.table_index  = TI_W'(fi_reg);
                r.entry_index  = si_reg;
                r.value        = copy ? VAL_W'(offset_reg) : {blk_fw, 32'd2};
                r.copies_block = copy;
                batch.res[idx] = r;
                idx            = idx + 2'd1;
            end
            if (flush) begin
                r              = '0;
                r.kind         = KIND_FLUSH;
                r.table_index  = TI_W'(fi_reg);
                r.value        = VAL_W'(off1);
                batch.res[idx] = r;
                idx            = idx + 2'd1;
            end
            if (end_go) begin
                r              = '0;
                r.kind         = KIND_SUMMARY;
                r.value        = VAL_W'(off_sel);
                r.byte_total   = bytes_reg;
                batch.res[idx] = r;
                idx            = idx + 2'd1;
            end
        end
        if (idx != 2'd0) begin
            batch.res[idx - 2'd1].last = 1'b1;
        end
        batch.cnt = idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_bits_reg  <= MIN_BLOCK;
            second_bits_reg <= MIN_SECOND;
            first_bits_reg  <= MIN_FIRST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BLOCK_BITS:  block_bits_reg  <= cfg_data;
                REG_SECOND_BITS: second_bits_reg <= cfg_data[3:0];
                REG_FIRST_BITS:  first_bits_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign restart = !aresetn || cfg_hit || end_go;

    always_ff @(posedge aclk) begin
        if (restart) begin
            offset_reg <= off_rst;
            bytes_reg  <= '0;
            wib_reg    <= '0;
            si_reg     <= '0;
            fi_reg     <= '0;
            tm_reg     <= 1'b0;
            zero_reg   <= 1'b1;
            uni_reg    <= 1'b1;
            fw_reg     <= 32'd0;
            ovf_reg    <= 1'b0;
        end else if (err) begin
            ovf_reg <= 1'b1;
        end else if (data_ok) begin
            bytes_reg  <= bytes_reg + SIZE_W'(v_eff);
            fw_reg     <= fw_cur;
            zero_reg   <= z_d;
            uni_reg    <= u_d;
            offset_reg <= off_sel;
            if (fin) begin
                wib_reg <= '0;
                si_reg  <= wrap ? '0 : si_reg + SI_W'(1);
                fi_reg  <= fi_reg + FI_W'(wrap);
                tm_reg  <= flush ? 1'b0 : tm1;
            end else begin
                wib_reg <= wib_reg + WIB_W'(1);
            end
        end
    end

endmodule

@@ src/sibm_res_fifo.sv @@
`timescale 1ns / 1ps
// Result queue: takes up to three results per cycle, hands out one while m_ready is high.
module sibm_res_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  sibm_pkg::batch_t batch,
    output logic             space_ok,
    output logic             m_valid,
    input  logic             m_ready,
    output sibm_pkg::res_t   head
);
    import sibm_pkg::*;

    res_t             mem [RQ_DEPTH];
    logic [RQ_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RQ_AW:0]   count_reg;
    logic             pop;

    assign m_valid  = (count_reg != '0);
    assign pop      = m_valid && m_ready;
    assign head     = mem[rd_ptr_reg];
    // room for a full batch
    assign space_ok = (count_reg <= (RQ_AW+1)'(RQ_DEPTH - MAX_RES));

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (k < int'(batch.cnt)) begin
                mem[wr_ptr_reg + RQ_AW'(k)] <= batch.res[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + RQ_AW'(batch.cnt);
            rd_ptr_reg <= rd_ptr_reg + RQ_AW'(pop);
            count_reg  <= count_reg + (RQ_AW+1)'(batch.cnt) - (RQ_AW+1)'(pop);
        end
    end

endmodule

@@ src/sibm_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the block mapper, bound to the top level.
module sibm_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         cfg_we,
    input logic [1:0]   cfg_index,
    input logic [4:0]   cfg_data,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [39:0]  s_axis_tdata,
    input logic [0:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tlast
);
    import sibm_pkg::*;

    // a held result must not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // input backpressure only while results are queued
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("tready low with empty result queue");

    // summary closes its request and has no table or entry index
    a_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == KIND_SUMMARY |->
            m_axis_tlast && m_axis_tdata[30:0] == 31'd0)
        else $error("malformed summary");

    // an overflow error stands alone, with no value or size
    a_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == KIND_ERROR |->
            m_axis_tlast && m_axis_tdata[143:31] == 113'd0)
        else $error("malformed overflow error");

    // only map entries ask for a block copy
    a_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[95] |-> m_axis_tuser == KIND_ENTRY)
        else $error("copy request on a non-entry result");

endmodule

bind sparse_image_block_mapper_unit sibm_checker u_sibm_checker (.*);
